// ===== hw/rtl/mrip_pkg.sv =====
// Package for the masked ray intensity projection block.
// Holds the projection mode codes, register indexes, sizing constants and width helpers.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mrip_pkg;

	localparam int VOXEL_BITS         = 16;
	localparam int OUT_W              = 26;
	localparam int RAY_LENGTH_MAX_DEF = 1024;
	localparam int QUEUE_DEPTH        = 4;
	localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W            = 3;

	typedef enum logic [1:0] {
		PM_MAX = 2'd0,
		PM_AVG = 2'd1,
		PM_MIN = 2'd2,
		PM_SUM = 2'd3
	} proj_mode_t;

	typedef enum logic {
		REG_MODE = 1'b0,
		REG_MASK = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_PUT
	} back_state_t;

	function automatic int sum_width(input int ray_len);
		return $clog2(ray_len) + VOXEL_BITS + 1;
	endfunction

	function automatic int cnt_width(input int ray_len);
		return $clog2(ray_len + 1);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrip_queue.sv =====
// Short request queue between the front and the back of the projection block.
// Register-based FIFO of finished ray statistics; depends on mrip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrip_queue import mrip_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [W-1:0]      wdata,
	input  wire logic              pop,
	output logic      [W-1:0]      rdata,
	output logic                   empty,
	output logic      [QCNT_W-1:0] count
);

	logic [W-1:0]      entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wdata;
	end

	assign rdata = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mrip_front.sv =====
// Front part of the projection block: accepts voxels and keeps the per-ray statistics.
// At the end of a ray it hands the selected statistic to the queue; depends on mrip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrip_front import mrip_pkg::*; #(
	parameter int RAY_LENGTH_MAX = RAY_LENGTH_MAX_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic signed [VOXEL_BITS-1:0]           voxel_value,
	input  wire logic                                   mask_bit,
	input  wire logic                                   ray_last,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire proj_mode_t                             mode,
	input  wire logic                                   mask_en,
	input  wire logic [QCNT_W-1:0]                      q_count,
	output logic                                        q_push,
	output logic [2+sum_width(RAY_LENGTH_MAX)+cnt_width(RAY_LENGTH_MAX)-1:0] q_wdata
);

	localparam int SW = sum_width(RAY_LENGTH_MAX);
	localparam int CW = cnt_width(RAY_LENGTH_MAX);
	localparam logic signed [VOXEL_BITS-1:0] VMAX = {1'b0, {(VOXEL_BITS-1){1'b1}}};
	localparam logic signed [VOXEL_BITS-1:0] VMIN = {1'b1, {(VOXEL_BITS-1){1'b0}}};
	localparam logic signed [SW:0] SUM_HI =
		(SW+1)'(longint'(RAY_LENGTH_MAX) * ((longint'(1) << (VOXEL_BITS-1)) - 1));
	localparam logic signed [SW:0] SUM_LO =
		(SW+1)'(-(longint'(RAY_LENGTH_MAX) << (VOXEL_BITS-1)));
	localparam logic [CW-1:0] CNT_MAX = CW'(RAY_LENGTH_MAX);

	logic signed [VOXEL_BITS-1:0] max_q [2];
	logic signed [VOXEL_BITS-1:0] min_q [2];
	logic signed [SW-1:0]         sum_q [2];
	logic [CW-1:0]                cnt_q [2];
	logic signed [VOXEL_BITS-1:0] max_d [2];
	logic signed [VOXEL_BITS-1:0] min_d [2];
	logic signed [SW-1:0]         sum_d [2];
	logic [CW-1:0]                cnt_d [2];
	logic signed [SW:0]           sum_wide [2];
	logic                         upd [2];

	logic                         accept;
	logic                         ray_end;
	logic                         use_masked;
	logic                         fin_valid_q;
	proj_mode_t                   fin_mode_q;
	logic signed [VOXEL_BITS-1:0] fin_max_q;
	logic signed [VOXEL_BITS-1:0] fin_min_q;
	logic signed [SW-1:0]         fin_sum_q;
	logic [CW-1:0]                fin_cnt_q;
	logic signed [SW-1:0]         fin_val;

	assign in_stall = (q_count >= QCNT_W'(QUEUE_DEPTH - 1));
	assign accept   = in_valid && !in_stall;
	assign ray_end  = accept && ray_last;

	always_comb begin
		upd[0] = accept;
		upd[1] = accept && mask_en && mask_bit;
		for (int k = 0; k < 2; k++) begin
			max_d[k]    = max_q[k];
			min_d[k]    = min_q[k];
			sum_d[k]    = sum_q[k];
			cnt_d[k]    = cnt_q[k];
			sum_wide[k] = (SW+1)'(sum_q[k]) + (SW+1)'(voxel_value);
			if (upd[k]) begin
				if (voxel_value > max_q[k]) max_d[k] = voxel_value;
				if (voxel_value < min_q[k]) min_d[k] = voxel_value;
				if (sum_wide[k] > SUM_HI) sum_d[k] = SUM_HI[SW-1:0];
				else if (sum_wide[k] < SUM_LO) sum_d[k] = SUM_LO[SW-1:0];
				else sum_d[k] = sum_wide[k][SW-1:0];
				if (cnt_q[k] < CNT_MAX) cnt_d[k] = cnt_q[k] + 1'b1;
			end
		end
		use_masked = mask_en && (cnt_d[1] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_q <= 1'b0;
			for (int k = 0; k < 2; k++) begin
				max_q[k] <= VMIN;
				min_q[k] <= VMAX;
				sum_q[k] <= '0;
				cnt_q[k] <= '0;
			end
		end else begin
			fin_valid_q <= ray_end;
			for (int k = 0; k < 2; k++) begin
				if (ray_end) begin
					max_q[k] <= VMIN;
					min_q[k] <= VMAX;
					sum_q[k] <= '0;
					cnt_q[k] <= '0;
				end else begin
					max_q[k] <= max_d[k];
					min_q[k] <= min_d[k];
					sum_q[k] <= sum_d[k];
					cnt_q[k] <= cnt_d[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ray_end) begin
			fin_mode_q <= mode;
			fin_max_q  <= use_masked ? max_d[1] : max_d[0];
			fin_min_q  <= use_masked ? min_d[1] : min_d[0];
			fin_sum_q  <= use_masked ? sum_d[1] : sum_d[0];
			fin_cnt_q  <= use_masked ? cnt_d[1] : cnt_d[0];
		end
	end

	always_comb begin
		unique case (fin_mode_q)
			PM_MAX: fin_val = SW'(fin_max_q);
			PM_MIN: fin_val = SW'(fin_min_q);
			PM_AVG: fin_val = fin_sum_q;
			PM_SUM: fin_val = fin_sum_q;
			default: fin_val = fin_sum_q;
		endcase
	end

	assign q_push  = fin_valid_q;
	assign q_wdata = {fin_mode_q, fin_val, fin_cnt_q};

endmodule

`default_nettype wire

// ===== hw/rtl/mrip_back.sv =====
// Back part of the projection block: takes finished rays from the queue and forms the result.
// Averages go through a one-bit-per-cycle restoring divider; depends on mrip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrip_back import mrip_pkg::*; #(
	parameter int RAY_LENGTH_MAX = RAY_LENGTH_MAX_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [2+sum_width(RAY_LENGTH_MAX)+cnt_width(RAY_LENGTH_MAX)-1:0] q_rdata,
	input  wire logic                    q_empty,
	output logic                         q_pop,
	output logic signed [OUT_W-1:0]      projected_value,
	output logic                         out_valid,
	input  wire logic                    out_stall
);

	localparam int SW  = sum_width(RAY_LENGTH_MAX);
	localparam int CW  = cnt_width(RAY_LENGTH_MAX);
	localparam int SCW = $clog2(SW);

	back_state_t          state_q;
	back_state_t          state_d;
	proj_mode_t           e_mode;
	logic signed [SW-1:0] e_val;
	logic [CW-1:0]        e_cnt;
	logic                 out_free;
	logic                 load_out;
	logic                 load_div;
	logic                 put_div;

	logic [SW-1:0]        dvd_q;
	logic [CW-1:0]        rem_q;
	logic [CW-1:0]        dsr_q;
	logic [SCW-1:0]       step_q;
	logic                 neg_q;
	logic [CW:0]          trial;
	logic                 ge;
	logic [CW:0]          diff;
	logic signed [SW:0]   quo_s;

	logic                 out_valid_q;
	logic signed [OUT_W-1:0] out_q;

	assign {e_mode, e_val, e_cnt} = q_rdata;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		load_div = 1'b0;
		put_div  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (e_mode == PM_AVG) begin
						load_div = 1'b1;
						state_d  = BK_DIV;
					end else begin
						load_out = 1'b1;
					end
				end
			end
			BK_DIV: begin
				if (step_q == SCW'(SW - 1)) state_d = BK_PUT;
			end
			BK_PUT: begin
				if (out_free) begin
					put_div = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign trial = {rem_q, dvd_q[SW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});
	assign quo_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

	always_ff @(posedge clk) begin
		if (load_div) begin
			dvd_q  <= e_val[SW-1] ? SW'(-e_val) : SW'(e_val);
			neg_q  <= e_val[SW-1];
			dsr_q  <= e_cnt;
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			dvd_q  <= {dvd_q[SW-2:0], ge};
			rem_q  <= ge ? diff[CW-1:0] : trial[CW-1:0];
			step_q <= step_q + 1'b1;
		end
		if (load_out) out_q <= OUT_W'(e_val);
		else if (put_div) out_q <= OUT_W'(quo_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out || put_div) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	assign out_valid       = out_valid_q;
	assign projected_value = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/masked_ray_intensity_projection.sv =====
// Masked ray intensity projection: one voxel per cycle in, one projected value per ray out.
// Voxels are taken every cycle while the ray queue has room; a result passes the front's final
// registers, the ray queue and the output register; an average also the restoring divider.
// The back end takes a new ray only in its idle state and takes none while it divides.
// Reset empties all statistics and the queue and clears the output valid and mode registers.
`timescale 1ns / 1ps
`default_nettype none

module masked_ray_intensity_projection import mrip_pkg::*; #(
	parameter int RAY_LENGTH_MAX = RAY_LENGTH_MAX_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [PADDR_W-1:0]           paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic signed [VOXEL_BITS-1:0] voxel_value,
	input  wire logic                         mask_bit,
	input  wire logic                         ray_last,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	output logic signed [OUT_W-1:0]           projected_value,
	output logic                              out_valid,
	input  wire logic                         out_stall
);

	localparam int QW = 2 + sum_width(RAY_LENGTH_MAX) + cnt_width(RAY_LENGTH_MAX);

	proj_mode_t        mode_q;
	logic              mask_en_q;
	reg_idx_t          reg_sel;
	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	logic [QW-1:0]     q_wdata;
	logic [QW-1:0]     q_rdata;
	logic [QCNT_W-1:0] q_count;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= PM_MAX;
			mask_en_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_MODE: mode_q    <= proj_mode_t'(pwdata[1:0]);
				REG_MASK: mask_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MODE: prdata = {30'd0, mode_q};
			REG_MASK: prdata = {31'd0, mask_en_q};
			default:  prdata = '0;
		endcase
	end

	mrip_front #(
		.RAY_LENGTH_MAX(RAY_LENGTH_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.voxel_value(voxel_value),
		.mask_bit   (mask_bit),
		.ray_last   (ray_last),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode_q),
		.mask_en    (mask_en_q),
		.q_count    (q_count),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	mrip_queue #(
		.W(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.count (q_count)
	);

	mrip_back #(
		.RAY_LENGTH_MAX(RAY_LENGTH_MAX)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_rdata        (q_rdata),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.projected_value(projected_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall)
	);

endmodule

`default_nettype wire

// ===== bench/masked_ray_intensity_projection_test.sv =====
// Self-checking testbench for the masked ray intensity projection block.
// Streams voxel rays with random idling, predicts each projected value and checks it in order.
// Depends on mrip_pkg and the masked_ray_intensity_projection top level.
`timescale 1ns / 1ps

module masked_ray_intensity_projection_test;
	import mrip_pkg::*;

	localparam int RAY_LEN     = RAY_LENGTH_MAX_DEF;
	localparam int TOTAL_W     = $clog2(RAY_LEN) + VOXEL_BITS + 1;
	localparam int COUNT_W     = $clog2(RAY_LEN + 1);
	localparam int VOX_HI      = (1 << (VOXEL_BITS - 1)) - 1;
	localparam int VOX_LO      = -VOX_HI - 1;
	localparam int SETTLE      = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 100;
	localparam int MAX_PRINTS  = 100;

	localparam proj_mode_t PHASE_MODES [8] = '{PM_MAX, PM_AVG, PM_MIN, PM_SUM,
		PM_MAX, PM_AVG, PM_MIN, PM_SUM};
	localparam bit PHASE_MASKS [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

	typedef struct packed {
		logic signed [VOXEL_BITS-1:0] intensity;
		logic                         masked;
		logic                         ray_end;
	} voxel_req_t;

	typedef struct {
		logic signed [VOXEL_BITS-1:0] peak;
		logic signed [VOXEL_BITS-1:0] trough;
		logic signed [TOTAL_W-1:0]    total;
		logic [COUNT_W-1:0]           n;
	} ray_stats_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [PADDR_W-1:0]           paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic signed [VOXEL_BITS-1:0] voxel_value = '0;
	logic                         mask_bit = 1'b0;
	logic                         ray_last = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [OUT_W-1:0]      projected_value;
	logic                         out_valid;
	logic                         out_stall = 1'b0;

	voxel_req_t              voxel_queue[$];
	logic signed [OUT_W-1:0] expected_projections[$];
	ray_stats_t              all_voxels;
	ray_stats_t              masked_voxels;
	proj_mode_t              mode_shadow = PM_MAX;
	logic                    mask_shadow = 1'b0;
	logic                    idle_on = 1'b0;
	logic                    holdoff_go = 1'b0;
	logic                    rx_hold = 1'b0;
	int                      send_gap = 0;
	int                      rx_gap = 0;
	int                      error_count = 0;

	masked_ray_intensity_projection DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.voxel_value(voxel_value),
		.mask_bit(mask_bit),
		.ray_last(ray_last),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.projected_value(projected_value),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic ray_stats_t stats_empty();
		ray_stats_t s;
		s.peak = VOX_LO;
		s.trough = VOX_HI;
		s.total = '0;
		s.n = '0;
		return s;
	endfunction

	function automatic ray_stats_t stats_accumulate(ray_stats_t s,
			logic signed [VOXEL_BITS-1:0] v);
		logic signed [TOTAL_W:0] t;
		if (v > s.peak) begin
			s.peak = v;
		end
		if (v < s.trough) begin
			s.trough = v;
		end
		t = s.total + v;
		if (t > RAY_LEN * VOX_HI) begin
			t = RAY_LEN * VOX_HI;
		end
		if (t < RAY_LEN * VOX_LO) begin
			t = RAY_LEN * VOX_LO;
		end
		s.total = t[TOTAL_W-1:0];
		if (s.n < RAY_LEN) begin
			s.n = s.n + 1'b1;
		end
		return s;
	endfunction

	task automatic project_voxel(input voxel_req_t req);
		ray_stats_t              chosen;
		logic signed [OUT_W-1:0] r;
		all_voxels = stats_accumulate(all_voxels, req.intensity);
		if (mask_shadow && req.masked) begin
			masked_voxels = stats_accumulate(masked_voxels, req.intensity);
		end
		if (req.ray_end) begin
			chosen = (mask_shadow && masked_voxels.n != 0) ? masked_voxels : all_voxels;
			case (mode_shadow)
				PM_MAX: r = chosen.peak;
				PM_AVG: r = chosen.total / $signed({1'b0, chosen.n});
				PM_MIN: r = chosen.trough;
				default: r = chosen.total;
			endcase
			expected_projections.push_back(r);
			all_voxels = stats_empty();
			masked_voxels = stats_empty();
		end
	endtask

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTS) begin
			$display("MISMATCH at %0t ns: %s", $time, what);
		end
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 30);
	endfunction

	function automatic void push_voxel(input logic signed [VOXEL_BITS-1:0] v,
			input logic m, input logic e);
		voxel_req_t req;
		req.intensity = v;
		req.masked = m;
		req.ray_end = e;
		voxel_queue.push_back(req);
	endfunction

	function automatic logic signed [VOXEL_BITS-1:0] pick_intensity();
		case ($urandom_range(0, 9))
			0: return VOX_HI;
			1: return VOX_LO;
			2: return $urandom_range(0, 8) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic int push_random_ray(input int max_len);
		int len, style, i;
		logic m;
		case ($urandom_range(0, 19))
			0: len = $urandom_range(17, 60);
			1, 2, 3: len = $urandom_range(5, 16);
			default: len = $urandom_range(1, 4);
		endcase
		if (len > max_len) begin
			len = $urandom_range(1, max_len);
		end
		style = $urandom_range(0, 4);
		for (i = 0; i < len; i++) begin
			m = (style == 0) ? 1'b0 : (style == 1) ? 1'b1 : 1'($urandom);
			push_voxel(pick_intensity(), m, i == len - 1);
		end
		return len;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE: mode_shadow = proj_mode_t'(value[1:0]);
			default: mask_shadow = value[0];
		endcase
	endtask

	task automatic wait_idle();
		while (voxel_queue.size() != 0 || in_valid || expected_projections.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input proj_mode_t mode, input logic mask);
		wait_idle();
		write_reg(REG_MODE, 32'(mode));
		write_reg(REG_MASK, 32'(mask));
	endtask

	// The sender offers one voxel request at a time and holds it while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall) begin
			end else if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (voxel_queue.size() != 0) begin
				voxel_value <= voxel_queue[0].intensity;
				mask_bit <= voxel_queue[0].masked;
				ray_last <= voxel_queue[0].ray_end;
				in_valid <= 1'b1;
				void'(voxel_queue.pop_front());
				send_gap <= idle_on ? pick_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			project_voxel('{voxel_value, mask_bit, ray_last});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_projections.size() == 0) begin
					report_mismatch($sformatf("unexpected projected_value %0d",
						projected_value));
				end else begin
					if (projected_value !== expected_projections[0]) begin
						report_mismatch($sformatf("projected_value %0d, expected %0d",
							projected_value, expected_projections[0]));
					end
					void'(expected_projections.pop_front());
				end
			end
			if (rx_hold) begin
				out_stall <= 1'b1;
			end else if (rx_gap != 0) begin
				out_stall <= 1'b1;
				rx_gap <= rx_gap - 1;
			end else begin
				out_stall <= 1'b0;
				rx_gap <= idle_on ? pick_gap() : 0;
			end
		end
	end

	// The receiver stops taking results for a long stretch so the ray queue fills up.
	initial begin
		wait (holdoff_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		int p, filled;
		all_voxels = stats_empty();
		masked_voxels = stats_empty();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on <= 1'b1;

		configure(PM_MAX, 1'b0);
		push_voxel(VOX_HI, 1'b0, 1'b1);
		push_voxel(VOX_LO, 1'b1, 1'b1);
		push_voxel(0, 1'b0, 1'b0);
		push_voxel(5, 1'b1, 1'b0);
		push_voxel(-3, 1'b0, 1'b1);
		configure(PM_AVG, 1'b1);
		push_voxel(-7, 1'b1, 1'b0);
		push_voxel(2, 1'b0, 1'b0);
		push_voxel(-2, 1'b1, 1'b1);
		push_voxel(10, 1'b0, 1'b0);
		push_voxel(11, 1'b0, 1'b1);
		push_voxel(-5, 1'b0, 1'b0);
		push_voxel(2, 1'b0, 1'b1);
		configure(PM_MIN, 1'b1);
		push_voxel(5, 1'b1, 1'b0);
		push_voxel(-100, 1'b0, 1'b0);
		push_voxel(7, 1'b1, 1'b1);
		configure(PM_SUM, 1'b0);
		push_voxel(100, 1'b1, 1'b0);
		push_voxel(200, 1'b1, 1'b0);
		push_voxel(-50, 1'b0, 1'b1);

		// Masking is turned off in the middle of one ray and on again in the middle of the next.
		configure(PM_MAX, 1'b1);
		push_voxel(3, 1'b1, 1'b0);
		push_voxel(9, 1'b0, 1'b0);
		configure(PM_MAX, 1'b0);
		push_voxel(1, 1'b1, 1'b1);
		push_voxel(9, 1'b0, 1'b0);
		push_voxel(3, 1'b1, 1'b0);
		configure(PM_MAX, 1'b1);
		push_voxel(1, 1'b1, 1'b1);

		for (p = 0; p < 8; p++) begin
			configure(PHASE_MODES[p], PHASE_MASKS[p]);
			idle_on <= (p % 3 != 1) && (p != 2);
			if (p == 2) begin
				holdoff_go <= 1'b1;
			end
			filled = 0;
			while (filled < PHASE_ITEMS) begin
				filled += push_random_ray(p == 2 ? 3 : 60);
			end
		end

		wait_idle();
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mrip_pkg.sv
hw/rtl/mrip_queue.sv
hw/rtl/mrip_front.sv
hw/rtl/mrip_back.sv
hw/rtl/masked_ray_intensity_projection.sv
bench/masked_ray_intensity_projection_test.sv
